@@ rtl/triangle_face_normal_packer_assert.svh @@
// Assertion macros shared by the triangle face normal packer modules.
`ifndef TRIANGLE_FACE_NORMAL_PACKER_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TFN_ASSERT_IMPL(label, clk, rst, prop, msg)
`define TFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/tfn_pkg.sv @@
// Shared types and constants for the triangle face normal packer.
package tfn_pkg;
   localparam int CoordW = 32;
   localparam int NormW = 16;
   localparam int ReqW = 5 * CoordW;
   localparam int RspW = 5 * CoordW + 3 * NormW;
   localparam int QueueDepth = 2;

   // One complete triangle handed from the front end to the back end.
   typedef struct packed {
      logic [2:0][2:0][CoordW-1:0] pos;
      logic [2:0][1:0][CoordW-1:0] tex;
      logic                        tex_en;
   } tri_type;

   // Status of the normalizer unit.
   typedef struct packed {
      logic busy;
      logic done;
   } norm_stat_type;
endpackage

@@ rtl/tfn_front.sv @@
// Front end: collects vertices into triangles and pushes them on a short queue.
module tfn_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [tfn_pkg::ReqW-1:0]  req_tdata,
   input  logic                      tex_en,
   output logic                      tri_valid,
   input  logic                      tri_ready,
   output tfn_pkg::tri_type          tri_data
);
   import tfn_pkg::*;
   `include "triangle_face_normal_packer_assert.svh"

   logic [1:0]                 count_ff, count_in;
   logic [1:0][2:0][CoordW-1:0] hpos_ff;
   logic [1:0][1:0][CoordW-1:0] htex_ff;
   tri_type                    q_ff [QueueDepth];
   logic                       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]                 fill_ff, fill_in;
   logic                       acc, push, pop;
   tri_type                    tri_new;

   // A vertex is taken unless it closes a triangle and the queue is full.
   assign req_tready = (count_ff != 2'd2) || (fill_ff != 2'(QueueDepth));
   assign acc = req_tvalid && req_tready;
   assign push = acc && (count_ff == 2'd2);
   assign pop = tri_valid && tri_ready;
   assign tri_valid = fill_ff != 2'd0;
   assign tri_data = q_ff[rp_ff];

   // Assemble the triangle from the two held vertices and the incoming one.
   always_comb begin
      tri_new.pos[0] = hpos_ff[0];
      tri_new.pos[1] = hpos_ff[1];
      tri_new.pos[2] = req_tdata[3*CoordW-1:0];
      tri_new.tex[0] = htex_ff[0];
      tri_new.tex[1] = htex_ff[1];
      tri_new.tex[2] = req_tdata[5*CoordW-1:3*CoordW];
      tri_new.tex_en = tex_en;
   end

   // Queue pointers and vertex count.
   always_comb begin
      count_in = count_ff;
      if (acc) count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         fill_ff <= fill_in;
      end
   end

   // Held vertices and queue storage.
   always_ff @(posedge clock) begin
      if (acc && count_ff != 2'd2) begin
         hpos_ff[count_ff[0]] <= req_tdata[3*CoordW-1:0];
         htex_ff[count_ff[0]] <= req_tdata[5*CoordW-1:3*CoordW];
      end
      if (push) q_ff[wp_ff] <= tri_new;
   end

   `TFN_ASSERT_IMPL(a_fill_max, clock, reset, fill_ff <= 2'(QueueDepth), "queue overfilled")
   `TFN_ASSERT_IMPL(a_count_max, clock, reset, count_ff != 2'd3, "bad vertex count")
   `TFN_ASSERT_NEXT(a_push_fill, clock, reset, push && !pop, fill_ff != 2'd0,
                    "push lost")
endmodule

@@ rtl/tfn_norm.sv @@
// Normalizer: cross product, then iterative square root and divider for the face normal.
module tfn_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [2:0][2:0][tfn_pkg::CoordW-1:0] pos,
   output tfn_pkg::norm_stat_type            stat,
   output logic [2:0][tfn_pkg::NormW-1:0]    normal,
   output logic                              degen
);
   import tfn_pkg::*;
   `include "triangle_face_normal_packer_assert.svh"

   localparam logic [3:0] SIdle = 4'd0, SEdge = 4'd1, SMul = 4'd2, SSub = 4'd3,
      SShift = 4'd4, SSq = 4'd5, SSum = 4'd6, SSqrt = 4'd7, SDiv = 4'd8,
      SDone = 4'd9;

   logic [3:0]            st_ff, st_in;
   logic [2:0][32:0]      e1_ff, e2_ff;
   logic [5:0][65:0]      pr_ff;          // signed products
   logic [2:0]            neg_ff;
   logic [2:0][64:0]      cm_ff;          // cross magnitudes
   logic [2:0][29:0]      m_ff;
   logic [2:0][59:0]      sq_ff;
   logic [61:0]           rad_ff;
   logic [31:0]           root_ff;
   logic [63:0]           rem_ff;
   logic [4:0]            it_ff;
   logic [1:0]            comp_ff;
   logic [44:0]           dnum_ff;
   logic [15:0]           quo_ff;
   logic [5:0]            dit_ff;
   logic [2:0][NormW-1:0] nrm_ff;
   logic                  dg_ff;
   logic [6:0]            blen;
   logic [6:0]            sh;
   logic [2:0][65:0]      crs;
   logic [63:0]           trial;
   logic [32:0]           dtrial;
   logic [31:0]           drem_ff;

   assign stat.busy = st_ff != SIdle;
   assign stat.done = st_ff == SDone;
   assign normal = nrm_ff;
   assign degen = dg_ff;

   // Cross differences, bit length and shift.
   always_comb begin
      for (int i = 0; i < 3; i++) crs[i] = 66'(pr_ff[2*i]) - 66'(pr_ff[2*i+1]);
      blen = 7'd0;
      for (int b = 0; b < 65; b++)
         if (cm_ff[0][b] || cm_ff[1][b] || cm_ff[2][b]) blen = 7'(b + 1);
      sh = (blen > 7'd30) ? blen - 7'd30 : 7'd0;
      trial = {rem_ff[61:0], rad_ff[61:60]} - {30'd0, root_ff, 2'b01};
      dtrial = {drem_ff, dnum_ff[44]} - {1'b0, root_ff};
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         SIdle:  if (start) st_in = SEdge;
         SEdge:  st_in = SMul;
         SMul:   st_in = SSub;
         SSub:   st_in = SShift;
         SShift: st_in = SSq;
         SSq:    st_in = SSum;
         SSum:   st_in = SSqrt;
         SSqrt:  if (it_ff == 5'd31) st_in = (dg_ff ? SDone : SDiv);
         SDiv:   if (comp_ff == 2'd2 && dit_ff == 6'd45) st_in = SDone;
         SDone:  st_in = SIdle;
         default: st_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= SIdle;
      else st_ff <= st_in;
   end

   // Datapath: edges, all six products at once, magnitudes, shift, squares and sum, then bit-serial root and divide.
   always_ff @(posedge clock) begin
      case (st_ff)
         SEdge: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= 33'(signed'(pos[1][i])) - 33'(signed'(pos[0][i]));
               e2_ff[i] <= 33'(signed'(pos[2][i])) - 33'(signed'(pos[0][i]));
            end
         end
         SMul: begin
            pr_ff[0] <= 66'(signed'(e1_ff[1]) * signed'(e2_ff[2]));
            pr_ff[1] <= 66'(signed'(e1_ff[2]) * signed'(e2_ff[1]));
            pr_ff[2] <= 66'(signed'(e1_ff[2]) * signed'(e2_ff[0]));
            pr_ff[3] <= 66'(signed'(e1_ff[0]) * signed'(e2_ff[2]));
            pr_ff[4] <= 66'(signed'(e1_ff[0]) * signed'(e2_ff[1]));
            pr_ff[5] <= 66'(signed'(e1_ff[1]) * signed'(e2_ff[0]));
         end
         SSub: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= crs[i][65];
               cm_ff[i] <= crs[i][65] ? 65'(-crs[i]) : crs[i][64:0];
            end
         end
         SShift: begin
            for (int i = 0; i < 3; i++) m_ff[i] <= 30'(cm_ff[i] >> sh);
            dg_ff <= blen == 7'd0;
         end
         SSq: for (int i = 0; i < 3; i++) sq_ff[i] <= m_ff[i] * m_ff[i];
         SSum: begin
            rad_ff <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
            root_ff <= 32'd0;
            rem_ff <= 64'd0;
            it_ff <= 5'd0;
         end
         SSqrt: begin
            if (it_ff != 5'd31) begin
               if (!trial[63]) begin
                  rem_ff <= trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[61:0], rad_ff[61:60]};
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               rad_ff <= {rad_ff[59:0], 2'b00};
               it_ff <= it_ff + 5'd1;
            end else begin
               comp_ff <= 2'd0;
               dit_ff <= 6'd0;
               drem_ff <= 32'd0;
               dnum_ff <= {1'b0, m_ff[0], 14'd0} + 45'(root_ff[31:1]);
               nrm_ff <= '0;
            end
         end
         SDiv: begin
            if (dit_ff != 6'd45) begin
               if (!dtrial[32]) begin
                  drem_ff <= dtrial[31:0];
                  quo_ff <= {quo_ff[14:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[30:0], dnum_ff[44]};
                  quo_ff <= {quo_ff[14:0], 1'b0};
               end
               dnum_ff <= {dnum_ff[43:0], 1'b0};
               dit_ff <= dit_ff + 6'd1;
            end else begin
               nrm_ff[comp_ff] <= neg_ff[comp_ff] ? 16'(-quo_ff) : quo_ff;
               comp_ff <= comp_ff + 2'd1;
               dit_ff <= 6'd0;
               drem_ff <= 32'd0;
               quo_ff <= 16'd0;
               dnum_ff <= {1'b0, m_ff[2'(comp_ff + 2'd1)], 14'd0} + 45'(root_ff[31:1]);
            end
         end
         default: ;
      endcase
   end

   `TFN_ASSERT_NEXT(a_start_idle, clock, reset, start && st_ff == SIdle, st_ff == SEdge,
                    "normalizer did not start")
   `TFN_ASSERT_NEXT(a_done_once, clock, reset, st_ff == SDone, st_ff == SIdle,
                    "done held too long")
endmodule

@@ rtl/tfn_back.sv @@
// Back end: runs the normalizer on each triangle and sends three vertex results.
module tfn_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tri_valid,
   output logic                     tri_ready,
   input  tfn_pkg::tri_type         tri_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [tfn_pkg::RspW-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser
);
   import tfn_pkg::*;
   `include "triangle_face_normal_packer_assert.svh"

   localparam logic [1:0] BIdle = 2'd0, BWait = 2'd1, BSend = 2'd2;

   logic [1:0]            st_ff, st_in;
   logic [1:0]            k_ff, k_in;
   norm_stat_type         nstat;
   logic [2:0][NormW-1:0] normal;
   logic                  degen;
   logic                  start;
   logic [CoordW-1:0]     u, v;

   assign start = (st_ff == BIdle) && tri_valid;
   assign tri_ready = (st_ff == BSend) && rsp_tready && (k_ff == 2'd2);
   assign rsp_tvalid = st_ff == BSend;
   assign u = tri_data.tex_en ? tri_data.tex[k_ff][0] : '0;
   assign v = tri_data.tex_en ? tri_data.tex[k_ff][1] : '0;
   assign rsp_tdata = {normal[2], normal[1], normal[0], v, u, tri_data.pos[k_ff][2],
                       tri_data.pos[k_ff][1], tri_data.pos[k_ff][0]};
   assign rsp_tuser = {k_ff == 2'd2, degen};

   tfn_norm u_norm (
      .clock(clock), .reset(reset), .start(start), .pos(tri_data.pos),
      .stat(nstat), .normal(normal), .degen(degen)
   );

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      case (st_ff)
         BIdle: if (tri_valid) st_in = BWait;
         BWait: if (nstat.done) begin
            st_in = BSend;
            k_in = 2'd0;
         end
         BSend: if (rsp_tready) begin
            if (k_ff == 2'd2) st_in = BIdle;
            else k_in = k_ff + 2'd1;
         end
         default: st_in = BIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BIdle;
         k_ff <= 2'd0;
      end else begin
         st_ff <= st_in;
         k_ff <= k_in;
      end
   end

   `TFN_ASSERT_IMPL(a_send_idle, clock, reset, !(st_ff == BSend && nstat.busy),
                    "normalizer busy while sending")
   `TFN_ASSERT_IMPL(a_k_range, clock, reset, k_ff != 2'd3, "bad vertex index")
endmodule

@@ rtl/triangle_face_normal_packer.sv @@
// Triangle face normal packer: vertices in, three results with normal per triangle.
// The normalizer takes a square root in 31 steps, then divides for each of the three
// normal components; a degenerate triangle skips the divide and gets a zero normal.
// The back end starts a new triangle only after the last result of the previous one is sent.
// The first two vertices of a triangle are always taken; the third waits while the queue is full.
// Reset is synchronous active high; it clears the count, queue and texture enable.
module triangle_face_normal_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v
   input  logic [tfn_pkg::ReqW-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_x, out_y, out_z, out_u, out_v, norm_x, norm_y, norm_z
   output logic [tfn_pkg::RspW-1:0] rsp_tdata,
   // degenerate, last_vertex
   output logic [1:0]               rsp_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);
   import tfn_pkg::*;

   logic    tex_en_ff;
   logic    tri_valid, tri_ready;
   tri_type tri_data;

   assign csr_ready = 1'b1;

   // Texture enable register.
   always_ff @(posedge clock) begin
      if (reset) tex_en_ff <= 1'b0;
      else if (csr_valid) tex_en_ff <= csr_data;
   end

   tfn_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .tex_en(tex_en_ff), .tri_valid(tri_valid),
      .tri_ready(tri_ready), .tri_data(tri_data)
   );

   tfn_back u_back (
      .clock(clock), .reset(reset), .tri_valid(tri_valid), .tri_ready(tri_ready),
      .tri_data(tri_data), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );
endmodule

@@ verif/tfn_checker.sv @@
// Result checker for the triangle face normal packer: predicts and compares each result.
module tfn_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [tfn_pkg::ReqW-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [tfn_pkg::RspW-1:0] rsp_tdata,
   input  logic [1:0]               rsp_tuser,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic                     csr_data,
   output int                       fail_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        last_vertex;
      logic        degenerate;
      logic [15:0] nz;
      logic [15:0] ny;
      logic [15:0] nx;
      logic [31:0] v;
      logic [31:0] u;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } vertex_rsp_type;

   vertex_rsp_type vertex_results[$];
   logic [2:0][4:0][31:0] held_verts;
   int  verts_held;
   logic tex_enable;

   assign pending_count = vertex_results.size();

   // Integer square root, floor.
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Compute the shared normal of a full triangle and queue three vertex results.
   task automatic predict_triangle();
      logic signed [32:0] e1 [3];
      logic signed [32:0] e2 [3];
      logic signed [67:0] c [3];
      logic [66:0] mag [3];
      longint unsigned m [3];
      longint unsigned sum, len, q;
      logic [15:0] nrm [3];
      int lmax, s, b;
      logic degen;
      vertex_rsp_type r;
      for (int i = 0; i < 3; i++) begin
         e1[i] = $signed({held_verts[1][i][31], held_verts[1][i]})
               - $signed({held_verts[0][i][31], held_verts[0][i]});
         e2[i] = $signed({held_verts[2][i][31], held_verts[2][i]})
               - $signed({held_verts[0][i][31], held_verts[0][i]});
      end
      c[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
      c[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
      c[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
      lmax = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? 67'(-c[i]) : 67'(c[i]);
         b = 0;
         for (int k = 0; k < 67; k++) if (mag[i][k]) b = k + 1;
         if (b > lmax) lmax = b;
      end
      degen = (lmax == 0);
      s = lmax > 30 ? lmax - 30 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = 64'(mag[i] >> s);
         sum += m[i] * m[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (!degen && len != 0) q = (m[i] * 16384 + len / 2) / len;
         if (c[i] < 0) q = -q;
         nrm[i] = q[15:0];
      end
      for (int k = 0; k < 3; k++) begin
         r.x = held_verts[k][0];
         r.y = held_verts[k][1];
         r.z = held_verts[k][2];
         r.u = tex_enable ? held_verts[k][3] : 32'd0;
         r.v = tex_enable ? held_verts[k][4] : 32'd0;
         r.nx = nrm[0];
         r.ny = nrm[1];
         r.nz = nrm[2];
         r.degenerate = degen;
         r.last_vertex = (k == 2);
         vertex_results.insert(vertex_results.size(), r);
      end
   endtask

   // Watch the three channels at every rising edge.
   always @(posedge clock) begin
      vertex_rsp_type want, got;
      if (reset) begin
         verts_held <= 0;
         tex_enable <= 1'b0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) tex_enable <= csr_data;
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 5; i++) held_verts[verts_held][i] = req_tdata[32*i +: 32];
            if (verts_held == 2) begin
               predict_triangle();
               verts_held <= 0;
            end else begin
               verts_held <= verts_held + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[1], rsp_tuser[0], rsp_tdata};
            if (vertex_results.size() == 0) begin
               $error("unexpected result transfer: x=%h", got.x);
               fail_count <= fail_count + 1;
            end else begin
               want = vertex_results.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (got.x !== want.x) $error("out_x exp %h got %h", want.x, got.x);
                  if (got.y !== want.y) $error("out_y exp %h got %h", want.y, got.y);
                  if (got.z !== want.z) $error("out_z exp %h got %h", want.z, got.z);
                  if (got.u !== want.u) $error("out_u exp %h got %h", want.u, got.u);
                  if (got.v !== want.v) $error("out_v exp %h got %h", want.v, got.v);
                  if (got.nx !== want.nx) $error("norm_x exp %h got %h", want.nx, got.nx);
                  if (got.ny !== want.ny) $error("norm_y exp %h got %h", want.ny, got.ny);
                  if (got.nz !== want.nz) $error("norm_z exp %h got %h", want.nz, got.nz);
                  if (got.degenerate !== want.degenerate)
                     $error("degenerate exp %b got %b", want.degenerate, got.degenerate);
                  if (got.last_vertex !== want.last_vertex)
                     $error("last_vertex exp %b got %b", want.last_vertex, got.last_vertex);
               end
            end
         end
      end
   end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the triangle face normal packer: stimulus, clock, reset and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [tfn_pkg::ReqW-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [tfn_pkg::RspW-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid, csr_ready, csr_data;
   int fail_count, pending_count, cycle_count;
   int send_idle_pct, recv_idle_pct;

   triangle_face_normal_packer dut (.*);

   tfn_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle limit guards against a hung handshake.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Send one vertex, idling at random before it is offered.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] u, logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v, u, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_triangle(logic [2:0][4:0][31:0] t);
      for (int k = 0; k < 3; k++) send_vertex(t[k][0], t[k][1], t[k][2], t[k][3], t[k][4]);
   endtask

   // Wait until all results are in, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_tex_enable(logic en);
      csr_valid <= 1'b1;
      csr_data <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                     : 32'h8000_0000 + $urandom_range(3);
         2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         default: return 32'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   task automatic random_triangles(int count);
      logic [2:0][4:0][31:0] t;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 5; i++) t[k][i] = random_coord();
         // Some triangles are collinear or repeat a vertex.
         if ($urandom_range(9) == 0) t[2][2:0] = t[$urandom_range(1)][2:0];
         else if ($urandom_range(9) == 0)
            for (int i = 0; i < 3; i++) t[2][i] = t[1][i] + (t[1][i] - t[0][i]);
         send_triangle(t);
      end
   endtask

   initial begin
      logic [31:0] mx, mn;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 65;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes with texturing off, unit axes, a degenerate triangle.
      send_triangle({{mx, mx, mx, mx, mx}, {mn, mn, mn, mn, mn}, {mx, mn, mx, mn, mx}});
      send_triangle({{32'd0, 32'h10000, 32'd0, 32'd5, 32'd6},
                     {32'h10000, 32'd0, 32'd0, 32'd3, 32'd4},
                     {32'd0, 32'd0, 32'd0, 32'd1, 32'd2}});
      send_triangle({{32'd7, 32'd7, 32'd7, mx, mn}, {32'd7, 32'd7, 32'd7, mn, mx},
                     {32'd7, 32'd7, 32'd7, 32'd1, 32'd1}});
      drain();
      write_tex_enable(1'b1);
      send_triangle({{mn, mx, mn, mn, mx}, {mx, mn, mx, mx, mn}, {mn, mn, mx, 32'd0, mx}});
      send_triangle({{32'd0, 32'd0, 32'd1, 32'd9, 32'd8},
                     {32'd0, 32'd1, 32'd0, 32'd7, 32'd6},
                     {32'd1, 32'd0, 32'd0, 32'd5, 32'd4}});
      send_triangle({{mx, mx, mx, mx, mx}, {mx, mx, mx, mn, mn}, {mx, mx, mx, 32'd0, 32'd0}});
      random_triangles(40);
      drain();

      // Phase two: roles of sender and receiver swapped, texturing off.
      write_tex_enable(1'b0);
      send_idle_pct = 65;
      recv_idle_pct = 37;
      random_triangles(40);
      drain();

      // Phase three: no idling, texturing on.
      write_tex_enable(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_triangles(45);
      drain();

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
